// ===== rtl/cubic_bspline_curve_sampler_unit_assert.svh =====
// assertion macros for the b-spline curve sampler
// no dependencies; included by the top level only
`ifndef CUBIC_BSPLINE_CURVE_SAMPLER_UNIT_ASSERT_SVH
`define CUBIC_BSPLINE_CURVE_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define CBSC_CHECK_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CBSC_CHECK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cbsc_pkg.sv =====
// shared constants and types for the b-spline curve sampler
// no dependencies
package cbsc_pkg;

    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_MAX_STEPS   = 63;
    localparam int CFG_W           = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic {
        KIND_FILL,
        KIND_SEG
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  new_curve;
    } t_q_head;

endpackage

// ===== rtl/cubic_bspline_curve_sampler_unit.sv =====
// uniform cubic b-spline sampler: a fill item only loads the window; a segment item
// evaluates N+1 samples (N = step count) through the per-sample weight/mac sequence
// and the bit-serial rounding divider
// a queue of two items in front lets input transfers continue during a segment
// synchronous active-low reset: window fill count, dedup memory and queue cleared,
// step count back to 32
module cubic_bspline_curve_sampler_unit #(
    parameter int COORD_WIDTH = cbsc_pkg::DEF_COORD_WIDTH,
    parameter int MAX_STEPS   = cbsc_pkg::DEF_MAX_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl_y,
    input  logic                          i_new_curve,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_curve_x,
    output logic signed [COORD_WIDTH-1:0] o_curve_y,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_we,
    input  logic [cbsc_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import cbsc_pkg::*;

`include "cubic_bspline_curve_sampler_unit_assert.svh"

    logic [CFG_W-1:0]              r_segment_steps;
    t_q_head                       w_head;
    logic signed [COORD_WIDTH-1:0] w_head_x;
    logic signed [COORD_WIDTH-1:0] w_head_y;
    logic                          w_pop;
    logic [Q_CW-1:0]               w_level;

    // step count register, raw value; clamping happens in the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_steps <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_segment_steps <= i_cfg_wdata;
        end
    end

    // front: input transfer, fill/segment classification, queue
    cbsc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ctrl_x    (i_ctrl_x),
        .i_ctrl_y    (i_ctrl_y),
        .i_new_curve (i_new_curve),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_head_x    (w_head_x),
        .o_head_y    (w_head_y),
        .o_level     (w_level)
    );

    // back: window, sample evaluation, dedup and one-sample lookahead for
    // the end-of-run flag, output register
    cbsc_back #(.COORD_WIDTH(COORD_WIDTH), .MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_x      (w_head_x),
        .i_head_y      (w_head_y),
        .o_pop         (w_pop),
        .i_steps       (r_segment_steps),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_last_of_run (o_last_of_run)
    );

    // the back end never pops an empty queue
    `CBSC_CHECK_NOW(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_level != '0)
    // queue occupancy never exceeds its depth
    `CBSC_CHECK_NOW(a_level_bound, i_clk, i_rst_n, 1'b1, w_level <= Q_CW'(Q_DEPTH))
    // a full queue with no pop stays full and refuses input
    `CBSC_CHECK_NEXT(a_full_holds, i_clk, i_rst_n,
        (w_level == Q_CW'(Q_DEPTH)) && !w_pop, !o_in_ready)

endmodule

// ===== rtl/cbsc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on nothing
module cbsc_div #(
    parameter int NW = 41,
    parameter int DW = 21,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quot,
    output logic          o_done
);
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_dsh;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_ge;

    assign w_ge   = r_rem >= r_dsh;
    assign o_quot = r_q;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_dsh  <= NW'(i_den) << (QW - 1);
                r_q    <= '0;
                r_cnt  <= CNT_W'(QW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[QW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/cbsc_front.sv =====
// front end: accepts control points, classifies them, queues them
// depends on cbsc_pkg
module cbsc_front #(
    parameter int COORD_WIDTH = cbsc_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl_y,
    input  logic                          i_new_curve,
    input  logic                          i_pop,
    output cbsc_pkg::t_q_head             o_head,
    output logic signed [COORD_WIDTH-1:0] o_head_x,
    output logic signed [COORD_WIDTH-1:0] o_head_y,
    output logic [cbsc_pkg::Q_CW-1:0]     o_level
);
    import cbsc_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_qx [Q_DEPTH];
    logic signed [COORD_WIDTH-1:0] r_qy [Q_DEPTH];
    logic                          r_qn [Q_DEPTH];
    t_kind                         r_qk [Q_DEPTH];
    logic [Q_AW-1:0]               r_wp;
    logic [Q_AW-1:0]               r_rp;
    logic [Q_CW-1:0]               r_cnt;
    logic [1:0]                    r_held;
    logic [1:0]                    n_held_eff;
    logic                          w_push;

    assign o_in_ready = r_cnt != Q_CW'(Q_DEPTH);
    assign w_push     = i_in_valid && o_in_ready;
    assign n_held_eff = i_new_curve ? 2'd0 : r_held;

    assign o_head.valid     = r_cnt != '0;
    assign o_head.kind      = r_qk[r_rp];
    assign o_head.new_curve = r_qn[r_rp];
    assign o_head_x         = r_qx[r_rp];
    assign o_head_y         = r_qy[r_rp];
    assign o_level          = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else begin
            if (w_push) begin
                r_qx[r_wp] <= i_ctrl_x;
                r_qy[r_wp] <= i_ctrl_y;
                r_qn[r_wp] <= i_new_curve;
                // first three points of a curve only fill the window
                r_qk[r_wp] <= (n_held_eff == 2'd3) ? KIND_SEG : KIND_FILL;
                r_held     <= (n_held_eff == 2'd3) ? 2'd3 : n_held_eff + 2'd1;
                r_wp       <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CW'(w_push) - Q_CW'(i_pop);
        end
    end

endmodule

// ===== rtl/cbsc_back.sv =====
// back end: point window, basis weights, weighted sums, rounding, dedup, output
// depends on cbsc_pkg and cbsc_div
module cbsc_back #(
    parameter int COORD_WIDTH = cbsc_pkg::DEF_COORD_WIDTH,
    parameter int MAX_STEPS   = cbsc_pkg::DEF_MAX_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbsc_pkg::t_q_head             i_head,
    input  logic signed [COORD_WIDTH-1:0] i_head_x,
    input  logic signed [COORD_WIDTH-1:0] i_head_y,
    output logic                          o_pop,
    input  logic [cbsc_pkg::CFG_W-1:0]    i_steps,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_curve_x,
    output logic signed [COORD_WIDTH-1:0] o_curve_y,
    output logic                          o_last_of_run
);
    import cbsc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int S  = $clog2(MAX_STEPS + 1);
    localparam int CW = 3 * S;
    localparam int DW = CW + 3;
    localparam int SW = W + DW + 3;
    localparam int NW = SW + 1;
    localparam int QW = W + 1;
    localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_N2, S_N3, S_D, S_W1, S_W2, S_W3, S_MAC,
        S_DVS, S_DIV, S_EMIT, S_NEXT, S_FLUSH
    } t_state;

    t_state                r_state;
    logic signed [W-1:0]   r_win_x [3];
    logic signed [W-1:0]   r_win_y [3];
    logic signed [W-1:0]   r_p3x;
    logic signed [W-1:0]   r_p3y;
    logic [1:0]            r_fill;
    logic [S-1:0]          r_n;
    logic [S-1:0]          r_k;
    logic [2*S-1:0]        r_n2;
    logic [CW-1:0]         r_n3;
    logic [DW-1:0]         r_d;
    logic [2*S-1:0]        r_k2;
    logic [2*S-1:0]        r_t2;
    logic [CW-1:0]         r_k3;
    logic [CW-1:0]         r_t3;
    logic [CW-1:0]         r_k2n;
    logic [CW-1:0]         r_kn2;
    logic [DW-1:0]         r_b [4];
    logic [1:0]            r_j;
    logic signed [SW-1:0]  r_accx;
    logic signed [SW-1:0]  r_accy;
    logic                  r_negx;
    logic                  r_negy;
    logic signed [W-1:0]   r_lastx;
    logic signed [W-1:0]   r_lasty;
    logic                  r_have;
    logic signed [W-1:0]   r_pendx;
    logic signed [W-1:0]   r_pendy;
    logic                  r_pend_v;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_outx;
    logic signed [W-1:0]   r_outy;
    logic                  r_out_last;

    logic [S-1:0]          n_nsel;
    logic [S-1:0]          w_t;
    logic signed [W-1:0]   w_px;
    logic signed [W-1:0]   w_py;
    logic signed [SW-1:0]  w_prodx;
    logic signed [SW-1:0]  w_prody;
    logic [NW-1:0]         w_numx;
    logic [NW-1:0]         w_numy;
    logic                  w_dstart;
    logic [QW-1:0]         w_qx;
    logic [QW-1:0]         w_qy;
    logic                  w_ddone;
    logic                  w_ddone_y;
    logic signed [W-1:0]   w_rx;
    logic signed [W-1:0]   w_ry;
    logic                  w_dup;
    logic                  w_out_free;
    logic                  w_load;
    logic [1:0]            w_fidx;

    function automatic logic signed [W-1:0] f_sat(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        lim = QW'(1) << (W - 1);
        if (!neg) begin
            f_sat = (q >= lim) ? SAT_HI : q[W-1:0];
        end else begin
            f_sat = (q > lim) ? SAT_LO : W'(-q);
        end
    endfunction

    function automatic logic [NW-1:0] f_num(input logic signed [SW-1:0] a,
                                             input logic [DW-1:0] d);
        logic [SW-1:0] mag;
        mag   = a[SW-1] ? SW'(-a) : SW'(a);
        f_num = NW'(mag) + NW'(d >> 1);
    endfunction

    always_comb begin
        if (i_steps == '0) begin
            n_nsel = S'(1);
        end else if (i_steps > CFG_W'(MAX_STEPS)) begin
            n_nsel = S'(MAX_STEPS);
        end else begin
            n_nsel = S'(i_steps);
        end
    end

    assign w_t = r_n - r_k;

    always_comb begin
        case (r_j)
            2'd0:    begin w_px = r_win_x[0]; w_py = r_win_y[0]; end
            2'd1:    begin w_px = r_win_x[1]; w_py = r_win_y[1]; end
            2'd2:    begin w_px = r_win_x[2]; w_py = r_win_y[2]; end
            default: begin w_px = r_p3x;      w_py = r_p3y;      end
        endcase
    end

    assign w_prodx = SW'(w_px * $signed({1'b0, r_b[r_j]}));
    assign w_prody = SW'(w_py * $signed({1'b0, r_b[r_j]}));

    assign w_numx   = f_num(r_accx, r_d);
    assign w_numy   = f_num(r_accy, r_d);
    assign w_dstart = r_state == S_DVS;

    cbsc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_numx),
        .i_den   (r_d),
        .o_quot  (w_qx),
        .o_done  (w_ddone)
    );

    cbsc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_numy),
        .i_den   (r_d),
        .o_quot  (w_qy),
        .o_done  (w_ddone_y)
    );

    assign w_rx       = f_sat(r_negx, w_qx);
    assign w_ry       = f_sat(r_negy, w_qy);
    assign w_dup      = r_have && (w_rx == r_lastx) && (w_ry == r_lasty);
    assign w_out_free = !r_out_valid || i_out_ready;
    // a held sample moves into the output register this cycle
    assign w_load     = r_pend_v && w_out_free
                        && (((r_state == S_EMIT) && !w_dup) || (r_state == S_FLUSH));
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_fidx     = i_head.new_curve ? 2'd0 : r_fill;

    assign o_out_valid   = r_out_valid;
    assign o_curve_x     = r_outx;
    assign o_curve_y     = r_outy;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_have      <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_lastx     <= '0;
            r_lasty     <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        if (i_head.new_curve) begin
                            r_have  <= 1'b0;
                            r_lastx <= '0;
                            r_lasty <= '0;
                        end
                        if (i_head.kind == KIND_FILL) begin
                            r_win_x[w_fidx] <= i_head_x;
                            r_win_y[w_fidx] <= i_head_y;
                            r_fill          <= w_fidx + 2'd1;
                        end else begin
                            r_p3x   <= i_head_x;
                            r_p3y   <= i_head_y;
                            r_n     <= n_nsel;
                            r_state <= S_N2;
                        end
                    end
                end
                S_N2: begin
                    r_n2    <= (2*S)'(r_n) * (2*S)'(r_n);
                    r_state <= S_N3;
                end
                S_N3: begin
                    r_n3    <= CW'(r_n2) * CW'(r_n);
                    r_state <= S_D;
                end
                S_D: begin
                    r_d     <= DW'(r_n3) * DW'(6);
                    r_k     <= '0;
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_k2    <= (2*S)'(r_k) * (2*S)'(r_k);
                    r_t2    <= (2*S)'(w_t) * (2*S)'(w_t);
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_k3    <= CW'(r_k2) * CW'(r_k);
                    r_t3    <= CW'(r_t2) * CW'(w_t);
                    r_k2n   <= CW'(r_k2) * CW'(r_n);
                    r_kn2   <= CW'(r_n2) * CW'(r_k);
                    r_state <= S_W3;
                end
                S_W3: begin
                    // weights over 6n^3, all non-negative
                    r_b[0]  <= DW'(r_t3);
                    r_b[1]  <= DW'(r_k3) * DW'(3) + (DW'(r_n3) << 2)
                               - DW'(r_k2n) * DW'(6);
                    r_b[2]  <= DW'(r_k2n) * DW'(3) + DW'(r_kn2) * DW'(3)
                               + DW'(r_n3) - DW'(r_k3) * DW'(3);
                    r_b[3]  <= DW'(r_k3);
                    r_accx  <= '0;
                    r_accy  <= '0;
                    r_j     <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_accx <= r_accx + w_prodx;
                    r_accy <= r_accy + w_prody;
                    r_j    <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        r_state <= S_DVS;
                    end
                end
                S_DVS: begin
                    r_negx  <= r_accx[SW-1];
                    r_negy  <= r_accy[SW-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // both dividers run in lockstep
                    if (w_ddone && w_ddone_y) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_dup) begin
                        r_state <= S_NEXT;
                    end else if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_outx      <= r_pendx;
                            r_outy      <= r_pendy;
                            r_out_last  <= 1'b0;
                            r_out_valid <= 1'b1;
                        end
                        r_pendx  <= w_rx;
                        r_pendy  <= w_ry;
                        r_pend_v <= 1'b1;
                        r_lastx  <= w_rx;
                        r_lasty  <= w_ry;
                        r_have   <= 1'b1;
                        r_state  <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_k == r_n) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_W1;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_outx      <= r_pendx;
                            r_outy      <= r_pendy;
                            r_out_last  <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_pend_v    <= 1'b0;
                        end
                        r_win_x[0] <= r_win_x[1];
                        r_win_y[0] <= r_win_y[1];
                        r_win_x[1] <= r_win_x[2];
                        r_win_y[1] <= r_win_y[2];
                        r_win_x[2] <= r_p3x;
                        r_win_y[2] <= r_p3y;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the uniform cubic b-spline curve sampler
// depends on cbsc_pkg and cubic_bspline_curve_sampler_unit from the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbsc_pkg::*;

    localparam int CW = DEF_COORD_WIDTH;
    localparam int NMAX = DEF_MAX_STEPS;
    // up to three items may still be in flight: two queued and one in the back end
    localparam int DRAIN_CYCLES = 6000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } sample_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_ctrl_x;
    logic signed [CW-1:0] i_ctrl_y;
    logic                 i_new_curve;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [CW-1:0] o_curve_x;
    logic signed [CW-1:0] o_curve_y;
    logic                 o_last_of_run;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;

    cubic_bspline_curve_sampler_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ctrl_x     (i_ctrl_x),
        .i_ctrl_y     (i_ctrl_y),
        .i_new_curve  (i_new_curve),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_curve_x    (o_curve_x),
        .o_curve_y    (o_curve_y),
        .o_last_of_run(o_last_of_run),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // predictor state: three held points, fill count, dedup memory, step count
    longint    win_x[3];
    longint    win_y[3];
    int        held;
    longint    prev_x;
    longint    prev_y;
    bit        prev_valid;
    int        steps_reg;
    sample_t   pending_samples[$];
    int        errors;
    bit        calm;      // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** cubic_bspline_curve_sampler_unit: FAILED **");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void clear_curve();
        for (int i = 0; i < 3; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
        held = 0;
        prev_x = 0;
        prev_y = 0;
        prev_valid = 0;
    endfunction

    // signed rounding division, half away from zero
    function automatic longint round_div(input longint s, input longint d);
        longint mag;
        mag = (s < 0) ? -s : s;
        mag = (mag + d / 2) / d;
        return (s < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_coord(input longint v);
        longint hi;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // evaluate one control point, queuing the samples it produces
    function automatic void predict_point(input logic signed [CW-1:0] px,
                                          input logic signed [CW-1:0] py,
                                          input logic nc);
        longint n, d, t, b0, b1, b2, b3, sx, sy, rx, ry;
        int first_idx;
        sample_t s;
        if (nc) clear_curve();
        if (held < 3) begin
            win_x[held] = px;
            win_y[held] = py;
            held++;
            return;
        end
        n = steps_reg;
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        d = 6 * n * n * n;
        first_idx = pending_samples.size();
        for (longint k = 0; k <= n; k++) begin
            t = n - k;
            b0 = t * t * t;
            b1 = 3 * k * k * k - 6 * k * k * n + 4 * n * n * n;
            b2 = -3 * k * k * k + 3 * k * k * n + 3 * k * n * n + n * n * n;
            b3 = k * k * k;
            sx = win_x[0] * b0 + win_x[1] * b1 + win_x[2] * b2 + longint'(px) * b3;
            sy = win_y[0] * b0 + win_y[1] * b1 + win_y[2] * b2 + longint'(py) * b3;
            rx = clamp_coord(round_div(sx, d));
            ry = clamp_coord(round_div(sy, d));
            if (prev_valid && rx == prev_x && ry == prev_y) continue;
            s.x = rx[CW-1:0];
            s.y = ry[CW-1:0];
            s.last = 1'b0;
            pending_samples.insert(pending_samples.size(), s);
            prev_x = rx;
            prev_y = ry;
            prev_valid = 1;
        end
        if (pending_samples.size() > first_idx)
            pending_samples[pending_samples.size() - 1].last = 1'b1;
        win_x[0] = win_x[1]; win_y[0] = win_y[1];
        win_x[1] = win_x[2]; win_y[1] = win_y[2];
        win_x[2] = px;       win_y[2] = py;
    endfunction

    // result side: random stalls, each transfer compared with the oldest sample
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_samples.size() == 0) begin
                    report($sformatf("unexpected sample (%0d,%0d)", o_curve_x, o_curve_y));
                end else begin
                    sample_t e;
                    e = pending_samples.pop_front();
                    if (o_curve_x !== e.x)
                        report($sformatf("curve_x %0d, want %0d", o_curve_x, e.x));
                    if (o_curve_y !== e.y)
                        report($sformatf("curve_y %0d, want %0d", o_curve_y, e.y));
                    if (o_last_of_run !== e.last)
                        report($sformatf("last_of_run %0b, want %0b", o_last_of_run, e.last));
                end
            end
            i_out_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // one control point transfer, with a random idle gap ahead of it;
    // valid stays up after the transfer until the next idle cycle or drain
    task automatic send_point(input int px, input int py, input logic nc);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_ctrl_x    <= CW'(px);
        i_ctrl_y    <= CW'(py);
        i_new_curve <= nc;
        do @(posedge i_clk); while (!o_in_ready);
        predict_point(CW'(px), CW'(py), nc);
    endtask

    // wait for every sample, then let a point with no result finish too
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_steps(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        steps_reg = value & 6'h3f;
    endtask

    // reset step count, extreme coordinates, saturation-prone windows
    task automatic test_extremes();
        send_point(16'sh7fff, 16'sh8000, 1'b1);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        drain();
    endtask

    // step count of zero behaves as one; a constant window yields one sample, then none
    task automatic test_small_steps();
        write_steps(0);
        send_point(5, -5, 1'b1);
        send_point(5, -5, 1'b0);
        send_point(5, -5, 1'b0);
        send_point(5, -5, 1'b0);
        send_point(5, -5, 1'b0);
        drain();
        write_steps(1);
        send_point(0, 0, 1'b1);
        send_point(1, 1, 1'b0);
        send_point(-1, 3, 1'b0);
        send_point(2, -7, 1'b0);
        send_point(3, 3, 1'b0);
        // a new curve after only two points
        send_point(9, 9, 1'b1);
        send_point(9, 9, 1'b0);
        send_point(100, -100, 1'b1);
        drain();
    endtask

    // largest step count, rounding on halves
    task automatic test_max_steps();
        write_steps(NMAX);
        send_point(1, -1, 1'b1);
        send_point(2, -2, 1'b0);
        send_point(-3, 3, 1'b0);
        send_point(1000, -1000, 1'b0);
        drain();
    endtask

    // random curves: mostly long runs, some broken short ones
    task automatic test_random(input int count);
        int sent;
        int px, py;
        sent = 0;
        while (sent < count) begin
            if (sent % 25 == 0) begin
                drain();
                write_steps(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8));
            end
            calm = (sent >= count / 2) && (sent < count / 2 + 15);
            if ($urandom_range(1)) begin
                px = int'($urandom);
                py = int'($urandom);
            end else begin
                px = int'($urandom_range(200)) - 100;
                py = int'($urandom_range(200)) - 100;
            end
            send_point(px, py, ($urandom_range(19) == 0) || sent == 0);
            sent++;
        end
        calm = 0;
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ctrl_x    = '0;
        i_ctrl_y    = '0;
        i_new_curve = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        errors      = 0;
        calm        = 0;
        steps_reg   = 32;
        clear_curve();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_small_steps();
        test_max_steps();
        test_random(80);

        if (pending_samples.size() != 0)
            report($sformatf("%0d samples never arrived", pending_samples.size()));
        if (errors == 0) begin
            $display("** cubic_bspline_curve_sampler_unit: PASSED **");
        end else begin
            $display("** cubic_bspline_curve_sampler_unit: FAILED **");
        end
        $finish;
    end
endmodule
